FILE: src/multi_server_priority_dispatcher_unit_macros.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef MULTI_SERVER_PRIORITY_DISPATCHER_UNIT_MACROS_SVH
`define MULTI_SERVER_PRIORITY_DISPATCHER_UNIT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MSPD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mspd_pkg.sv
// Types and constants shared by the dispatcher modules.
`timescale 1ns / 1ps
`default_nettype none
package mspd_pkg;

  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int PRIO_W = 8;
  localparam int PUMP_W = 4;

  // Input commands
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Result kinds
  localparam logic KIND_SERVED  = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  localparam logic [PUMP_W-1:0] PUMP_COUNT_RESET = 4'd2;

  // One waiting request
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/mspd_order_cmp.sv
// Shared order compare: is a stored request served after a new one.
`timescale 1ns / 1ps
`default_nettype none
module mspd_order_cmp (
  input  mspd_pkg::entry_t stored,
  input  mspd_pkg::entry_t fresh,
  output logic             later
);
  import mspd_pkg::*;

  // Lower priority value first, then earlier arrival; ties keep insertion order
  always_comb begin
    if (stored.prio != fresh.prio) begin
      later = stored.prio > fresh.prio;
    end else begin
      later = stored.arrival > fresh.arrival;
    end
  end

endmodule
`default_nettype wire

FILE: src/mspd_queue_ram.sv
// Request store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mspd_queue_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  mspd_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output mspd_pkg::entry_t rdata
);
  import mspd_pkg::*;

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, hold the data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/multi_server_priority_dispatcher_unit.sv
// Top level of the priority dispatcher: sequencer, counters and result register.
//
// Usage: one input channel (in_valid/in_stall) carries commands. An arrive item
// inserts {vehicle_tag, arrival_time, priority_req} into a sorted queue; a tick
// item serves up to pump_count requests from the head, then bumps the time.
// The result channel (out_valid/out_stall) gives served and dropped items, with
// last set on the final result caused by one input item.
// pump_count is written through wr_en/wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. An
// arrive into an empty queue is written to the tail at once; otherwise the
// shared compare unit checks one entry per cycle over the single read port
// of the request store, each entry served later moves one place toward the
// tail, and the request is written into the gap. A dropped arrive (queue
// full) goes through S_DROP. A tick does one store read per served result.
// in_stall is high while an item is at work; a finished result may still wait
// in the output register while the next item is taken.
// When out_stall holds a waiting result, the register holds and S_POP/S_DROP wait.
// Reset empties the queue, clears the time counter and sets pump_count to 2;
// no clearing pass runs, the store is read only below the fill count.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_server_priority_dispatcher_unit_macros.svh"
module multi_server_priority_dispatcher_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_PUMPS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] vehicle_tag,
  input  logic [31:0] arrival_time,
  input  logic [7:0]  priority_req,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [15:0] served_tag,
  output logic [31:0] served_arrival,
  output logic [31:0] service_time,
  output logic        last,
  // configuration
  input  logic        wr_en,
  input  logic [3:0]  wr_data
);
  import mspd_pkg::*;

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = $clog2(MAX_PUMPS + 1);
  localparam int NW0 = (CW > PW) ? CW : PW;
  localparam int NW  = (NW0 > PUMP_W) ? NW0 : PUMP_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_CMP = 3'd1;
  localparam logic [2:0] S_INS_PUT = 3'd2;
  localparam logic [2:0] S_POP     = 3'd3;
  localparam logic [2:0] S_DROP    = 3'd4;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [AW-1:0]     wptr, wptr_next;
  logic [AW-1:0]     rptr, rptr_next;
  logic [CW-1:0]     walk, walk_next;
  logic [NW-1:0]     left, left_next;
  logic [TIME_W-1:0] current_time, time_next;
  logic [PUMP_W-1:0] pump_count;
  entry_t            ins;
  logic              ins_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  logic              later;

  logic              accept;
  logic              full;
  logic              out_free;
  logic              out_load;
  logic              out_kind_d;
  logic [TAG_W-1:0]  out_tag_d;
  logic [TIME_W-1:0] out_arr_d;
  logic              out_last_d;
  logic [NW-1:0]     pump_sat;
  logic [NW-1:0]     serve_n;
  entry_t            in_entry;

  // Circular pointer steps
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  mspd_queue_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mspd_order_cmp u_cmp (
    .stored (ram_rdata),
    .fresh  (ins),
    .later  (later)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(QUEUE_DEPTH));
  assign out_free = !out_valid || !out_stall;
  assign in_entry = '{tag: vehicle_tag, arrival: arrival_time, prio: priority_req};

  // Size of the serve run: pump_count, saturated, limited by the fill count
  always_comb begin
    pump_sat = NW'(pump_count);
    if (pump_sat > NW'(MAX_PUMPS)) begin
      pump_sat = NW'(MAX_PUMPS);
    end
    serve_n = (pump_sat > NW'(count)) ? NW'(count) : pump_sat;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    head_next  = head;
    tail_next  = tail;
    wptr_next  = wptr;
    rptr_next  = rptr;
    walk_next  = walk;
    left_next  = left;
    time_next  = current_time;
    ins_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wptr;
    ram_wdata  = ins;
    ram_re     = 1'b0;
    ram_raddr  = head;
    out_load   = 1'b0;
    out_kind_d = KIND_SERVED;
    out_tag_d  = ram_rdata.tag;
    out_arr_d  = ram_rdata.arrival;
    out_last_d = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_ARRIVE) begin
            ins_load = 1'b1;
            if (full) begin
              state_next = S_DROP;
            end else begin
              count_next = count + 1'b1;
              tail_next  = ptr_inc(tail);
              if (count == '0) begin
                // empty queue: place at the tail directly
                ram_we    = 1'b1;
                ram_waddr = tail;
                ram_wdata = in_entry;
              end else begin
                // start the walk from the tail toward the head
                ram_re     = 1'b1;
                ram_raddr  = ptr_dec(tail);
                wptr_next  = tail;
                rptr_next  = ptr_dec(tail);
                walk_next  = count;
                state_next = S_INS_CMP;
              end
            end
          end else begin
            if (serve_n == '0) begin
              time_next = current_time + 1'b1;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = head;
              left_next  = serve_n;
              state_next = S_POP;
            end
          end
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = wptr;
        if (later) begin
          // shift the stored entry one place toward the tail
          ram_wdata = ram_rdata;
          wptr_next = rptr;
          if (walk != CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec(rptr);
            rptr_next = ptr_dec(rptr);
            walk_next = walk - 1'b1;
          end else begin
            state_next = S_INS_PUT;
          end
        end else begin
          ram_wdata  = ins;
          state_next = S_IDLE;
        end
      end
      S_INS_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = wptr;
        ram_wdata  = ins;
        state_next = S_IDLE;
      end
      S_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = (left == NW'(1));
          head_next  = ptr_inc(head);
          count_next = count - 1'b1;
          left_next  = left - 1'b1;
          if (left != NW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc(head);
          end else begin
            time_next  = current_time + 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_DROP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_DROPPED;
          out_tag_d  = ins.tag;
          out_arr_d  = ins.arrival;
          out_last_d = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      head         <= '0;
      tail         <= '0;
      current_time <= '0;
      pump_count   <= PUMP_COUNT_RESET;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      head         <= head_next;
      tail         <= tail_next;
      current_time <= time_next;
      if (wr_en) begin
        pump_count <= wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk registers and held request
  always_ff @(posedge clk) begin
    wptr <= wptr_next;
    rptr <= rptr_next;
    walk <= walk_next;
    left <= left_next;
    if (ins_load) begin
      ins <= in_entry;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind           <= out_kind_d;
      served_tag     <= out_tag_d;
      served_arrival <= out_arr_d;
      service_time   <= current_time;
      last           <= out_last_d;
    end
  end

  `MSPD_ASSERT_ALWAYS(a_count_bound, count <= CW'(QUEUE_DEPTH), "fill count above depth")
  `MSPD_ASSERT_ALWAYS(a_walk_live, (state != S_INS_CMP) || (walk != '0), "insert walk ran out")
  `MSPD_ASSERT_ALWAYS(a_pop_live, (state != S_POP) || ((left != '0) && (count != '0)), "serving from empty queue")
  `MSPD_ASSERT_NEXT(a_idle_tick, accept && (command == CMD_TICK) && (serve_n == '0), (current_time == $past(current_time) + 32'd1) && (state == S_IDLE), "empty tick did not advance time")

endmodule
`default_nettype wire
